// ===== src/color_key_sprite_blitter_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Color key sprite blitter assertion macros
// Shared concurrent assertion forms for the blitter.
// ---------------------------------------------------------------------------
`ifndef COLOR_KEY_SPRITE_BLITTER_UNIT_ASSERT_SVH
`define COLOR_KEY_SPRITE_BLITTER_UNIT_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define CKB_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("blitter check failed in the same cycle");

// Next-cycle implication, held off during reset.
`define CKB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("blitter check failed one cycle later");

`endif

// ===== src/ckb_pkg.sv =====
// ---------------------------------------------------------------------------
// Color key sprite blitter package
// Shared widths, register indexes, reset values and the settings struct.
// ---------------------------------------------------------------------------
package ckb_pkg;

   localparam int MAX_DIM_DEFAULT = 4096;

   localparam int CFG_DIM_W   = 13;
   localparam int PLACE_W     = 13;
   localparam int PIXEL_W     = 32;
   localparam int DEST_W      = 12;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PLACE_X       = 3'd0,
      REG_PLACE_Y       = 3'd1,
      REG_REGION_WIDTH  = 3'd2,
      REG_REGION_HEIGHT = 3'd3,
      REG_TARGET_WIDTH  = 3'd4,
      REG_TARGET_HEIGHT = 3'd5,
      REG_KEY_COLOR     = 3'd6,
      REG_KEY_ENABLE    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [PLACE_W-1:0] place_x;
      logic signed [PLACE_W-1:0] place_y;
      logic [CFG_DIM_W-1:0]      region_width;
      logic [CFG_DIM_W-1:0]      region_height;
      logic [CFG_DIM_W-1:0]      target_width;
      logic [CFG_DIM_W-1:0]      target_height;
      logic [PIXEL_W-1:0]        key_color;
      logic                      key_enable;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      place_x:       '0,
      place_y:       '0,
      region_width:  13'd1,
      region_height: 13'd1,
      target_width:  13'd4096,
      target_height: 13'd4096,
      key_color:     '0,
      key_enable:    1'b0
   };

   // Result of the placement and write decision for one pixel.
   typedef struct packed {
      logic              strobe;
      logic [DEST_W-1:0] col;
      logic [DEST_W-1:0] row;
   } place_type;

endpackage

// ===== src/ckb_locate.sv =====
// ---------------------------------------------------------------------------
// Color key sprite blitter pixel locator
// Places one region pixel on the target, clips it and applies the color key.
// ---------------------------------------------------------------------------
module ckb_locate #(
   parameter int MAX_DIM = ckb_pkg::MAX_DIM_DEFAULT
) (
   input  ckb_pkg::cfg_type               cfg,
   input  logic [$clog2(MAX_DIM)-1:0]     col_count,
   input  logic [$clog2(MAX_DIM)-1:0]     row_count,
   input  logic [ckb_pkg::PIXEL_W-1:0]    pixel,
   output ckb_pkg::place_type             place
);

   localparam int CW = $clog2(MAX_DIM);
   localparam int DW = CW + 1;
   localparam int EW = (DW > ckb_pkg::CFG_DIM_W) ? DW : ckb_pkg::CFG_DIM_W;
   localparam int SW = EW + 1;
   localparam logic [EW-1:0] DIM_MAX = EW'(MAX_DIM);

   logic [EW-1:0]        tw;
   logic [EW-1:0]        th;
   logic signed [SW-1:0] dc;
   logic signed [SW-1:0] dr;
   logic                 on_target;
   logic                 keyed;

   always_comb begin
      tw = EW'(cfg.target_width);
      th = EW'(cfg.target_height);
      if (tw > DIM_MAX) begin
         tw = DIM_MAX;
      end
      if (th > DIM_MAX) begin
         th = DIM_MAX;
      end
   end

   // Sum cannot overflow: offset and counter each stay within half the range.
   assign dc = SW'(cfg.place_x) + signed'({1'b0, EW'(col_count)});
   assign dr = SW'(cfg.place_y) + signed'({1'b0, EW'(row_count)});

   assign on_target = !dc[SW-1] && (dc[EW-1:0] < tw) && !dr[SW-1] && (dr[EW-1:0] < th);
   assign keyed     = cfg.key_enable && (pixel == cfg.key_color);

   always_comb begin
      place.strobe = on_target && !keyed;
      place.col    = place.strobe ? dc[ckb_pkg::DEST_W-1:0] : '0;
      place.row    = place.strobe ? dr[ckb_pkg::DEST_W-1:0] : '0;
   end

endmodule

// ===== src/color_key_sprite_blitter_unit.sv =====
// ---------------------------------------------------------------------------
// Color key sprite blitter
// Streams region pixels to clipped, color-keyed destination writes.
// ---------------------------------------------------------------------------
// The blitter takes one source pixel per transfer in raster order and returns
// one result per pixel: the destination column and row (placement offset plus
// the position inside the region), a write strobe that is high only when that
// spot lies on the target surface and the pixel is not the key color (with
// keying on), the pixel itself, and a mark on the region's last pixel. After
// the last pixel the position returns to the top-left, ready for the next
// region. Throughput is one pixel per clock while the result side keeps up;
// a pixel's result passes through the input register and then the result
// register. Both registers advance together, so a stalled result side backs
// up through them and only then drops req_ready. Write settings through the
// csr port only while no pixel is in flight. A region or target size above
// MAX_DIM acts as MAX_DIM, and a region size of zero acts as one.
// ---------------------------------------------------------------------------
`include "color_key_sprite_blitter_unit_assert.svh"

module color_key_sprite_blitter_unit #(
   parameter int MAX_DIM = ckb_pkg::MAX_DIM_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // Source pixel channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ckb_pkg::PIXEL_W-1:0]       req_src_pixel,
   // Result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_write_strobe,
   output logic [ckb_pkg::DEST_W-1:0]        rsp_dest_col,
   output logic [ckb_pkg::DEST_W-1:0]        rsp_dest_row,
   output logic [ckb_pkg::PIXEL_W-1:0]       rsp_out_pixel,
   output logic                              rsp_region_last,
   // Settings write port
   input  logic                              csr_write_enable,
   input  logic [ckb_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ckb_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CW = $clog2(MAX_DIM);
   localparam int DW = CW + 1;
   localparam int EW = (DW > ckb_pkg::CFG_DIM_W) ? DW : ckb_pkg::CFG_DIM_W;
   localparam logic [EW-1:0] DIM_MAX = EW'(MAX_DIM);
   localparam logic [EW-1:0] DIM_ONE = EW'(1);

   // Settings
   ckb_pkg::cfg_type cfg_ff, cfg_in;

   // Region position counters
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] row_ff, row_in;

   // Input register
   logic                          s1_valid_ff, s1_valid_in;
   logic [ckb_pkg::PIXEL_W-1:0]   s1_pixel_ff;
   logic [CW-1:0]                 s1_col_ff;
   logic [CW-1:0]                 s1_row_ff;
   logic                          s1_last_ff;

   // Result register
   logic                          rsp_valid_ff, rsp_valid_in;
   ckb_pkg::place_type            rsp_place_ff;
   logic [ckb_pkg::PIXEL_W-1:0]   rsp_pixel_ff;
   logic                          rsp_last_ff;

   logic               req_accept;
   logic               s1_advance;
   logic [EW-1:0]      rw;
   logic [EW-1:0]      rh;
   logic               row_end;
   logic               region_end;
   ckb_pkg::place_type s1_place;

   // ---- Settings decode --------------------------------------------------
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (ckb_pkg::csr_index_type'(csr_index))
            ckb_pkg::REG_PLACE_X:
               cfg_in.place_x = csr_wdata[ckb_pkg::PLACE_W-1:0];
            ckb_pkg::REG_PLACE_Y:
               cfg_in.place_y = csr_wdata[ckb_pkg::PLACE_W-1:0];
            ckb_pkg::REG_REGION_WIDTH:
               cfg_in.region_width = csr_wdata[ckb_pkg::CFG_DIM_W-1:0];
            ckb_pkg::REG_REGION_HEIGHT:
               cfg_in.region_height = csr_wdata[ckb_pkg::CFG_DIM_W-1:0];
            ckb_pkg::REG_TARGET_WIDTH:
               cfg_in.target_width = csr_wdata[ckb_pkg::CFG_DIM_W-1:0];
            ckb_pkg::REG_TARGET_HEIGHT:
               cfg_in.target_height = csr_wdata[ckb_pkg::CFG_DIM_W-1:0];
            ckb_pkg::REG_KEY_COLOR:
               cfg_in.key_color = csr_wdata[ckb_pkg::PIXEL_W-1:0];
            ckb_pkg::REG_KEY_ENABLE:
               cfg_in.key_enable = csr_wdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // ---- Handshake --------------------------------------------------------
   // The input register moves on whenever the result register is free or
   // being drained this cycle; the input side may then take a new pixel.
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_accept = req_valid && req_ready;

   // ---- Region walk ------------------------------------------------------
   // Effective region size: zero acts as one, oversize clamps to MAX_DIM.
   always_comb begin
      rw = EW'(cfg_ff.region_width);
      rh = EW'(cfg_ff.region_height);
      if (rw == '0) begin
         rw = DIM_ONE;
      end else if (rw > DIM_MAX) begin
         rw = DIM_MAX;
      end
      if (rh == '0) begin
         rh = DIM_ONE;
      end else if (rh > DIM_MAX) begin
         rh = DIM_MAX;
      end
   end

   // A counter at or past the last column or row counts as on it, so a
   // region shrunk mid-way still ends cleanly.
   assign row_end    = EW'(col_ff) >= (rw - DIM_ONE);
   assign region_end = row_end && (EW'(row_ff) >= (rh - DIM_ONE));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_accept) begin
         if (region_end) begin
            col_in = '0;
            row_in = '0;
         end else if (row_end) begin
            col_in = '0;
            row_in = row_ff + CW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   // ---- Pipeline control -------------------------------------------------
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---- Placement, clipping and keying ----------------------------------
   ckb_locate #(
      .MAX_DIM (MAX_DIM)
   ) u_locate (
      .cfg       (cfg_ff),
      .col_count (s1_col_ff),
      .row_count (s1_row_ff),
      .pixel     (s1_pixel_ff),
      .place     (s1_place)
   );

   // ---- Registers --------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= ckb_pkg::CFG_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: capture the pixel with its position, hold while stalled.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff <= req_src_pixel;
         s1_col_ff   <= col_ff;
         s1_row_ff   <= row_ff;
         s1_last_ff  <= region_end;
      end
      if (s1_advance) begin
         rsp_place_ff <= s1_place;
         rsp_pixel_ff <= s1_pixel_ff;
         rsp_last_ff  <= s1_last_ff;
      end
   end

   // ---- Outputs ----------------------------------------------------------
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_write_strobe = rsp_place_ff.strobe;
   assign rsp_dest_col     = rsp_place_ff.col;
   assign rsp_dest_row     = rsp_place_ff.row;
   assign rsp_out_pixel    = rsp_pixel_ff;
   assign rsp_region_last  = rsp_last_ff;

   // ---- Assertions -------------------------------------------------------
   // A pixel that is not written reports a zero destination.
   `CKB_ASSERT_NOW(a_idle_dest_zero, clock, reset, rsp_valid && !rsp_write_strobe, rsp_dest_col == '0 && rsp_dest_row == '0)
   // Ending a region returns the walk to the top-left.
   `CKB_ASSERT_NEXT(a_region_wrap, clock, reset, req_accept && region_end, col_ff == '0 && row_ff == '0)
   // An empty input register never refuses a pixel.
   `CKB_ASSERT_NOW(a_ready_when_empty, clock, reset, !s1_valid_ff, req_ready)
   // A stalled result keeps its place in line.
   `CKB_ASSERT_NEXT(a_stall_holds_last, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_last_ff))

endmodule

// ===== test/tb_color_key_sprite_blitter_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Color key sprite blitter testbench
// Streams pixel regions through the blitter under changing placement, clip
// and key settings, with random source gaps and result backpressure, and
// checks every result field against an in-bench model of the blitter.
// ---------------------------------------------------------------------------
module tb_color_key_sprite_blitter_unit;

   localparam int MAX_DIM      = ckb_pkg::MAX_DIM_DEFAULT;
   localparam int RESET_CYCLES = 11;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 10;
   localparam int RANDOM_ITEMS = 700;

   // One expected write decision, as the result channel should present it.
   typedef struct {
      ckb_pkg::place_type          spot;
      logic [ckb_pkg::PIXEL_W-1:0] pixel;
      logic                        last;
   } blit_write_type;

   logic                            clock;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [ckb_pkg::PIXEL_W-1:0]     req_src_pixel = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic                            rsp_write_strobe;
   logic [ckb_pkg::DEST_W-1:0]      rsp_dest_col;
   logic [ckb_pkg::DEST_W-1:0]      rsp_dest_row;
   logic [ckb_pkg::PIXEL_W-1:0]     rsp_out_pixel;
   logic                            rsp_region_last;
   logic                            csr_write_enable = 1'b0;
   logic [ckb_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [ckb_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // Settings as the blitter holds them, mirrored at every csr write.
   logic signed [ckb_pkg::PLACE_W-1:0] place_col = ckb_pkg::CFG_RESET.place_x;
   logic signed [ckb_pkg::PLACE_W-1:0] place_row = ckb_pkg::CFG_RESET.place_y;
   logic [ckb_pkg::CFG_DIM_W-1:0]      region_w  = ckb_pkg::CFG_RESET.region_width;
   logic [ckb_pkg::CFG_DIM_W-1:0]      region_h  = ckb_pkg::CFG_RESET.region_height;
   logic [ckb_pkg::CFG_DIM_W-1:0]      target_w  = ckb_pkg::CFG_RESET.target_width;
   logic [ckb_pkg::CFG_DIM_W-1:0]      target_h  = ckb_pkg::CFG_RESET.target_height;
   logic [ckb_pkg::PIXEL_W-1:0]        key_value = ckb_pkg::CFG_RESET.key_color;
   logic                               key_on    = ckb_pkg::CFG_RESET.key_enable;

   // Raster position inside the region.
   int col_pos = 0;
   int row_pos = 0;

   logic [ckb_pkg::PIXEL_W-1:0] pixel_backlog[$];
   blit_write_type              pending_writes[$];

   bit idle_on      = 1'b1;
   int gap_left     = 0;
   int stall_left   = 0;
   int quiet_cycles = 0;
   int error_count  = 0;

   color_key_sprite_blitter_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_src_pixel    (req_src_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_write_strobe (rsp_write_strobe),
      .rsp_dest_col     (rsp_dest_col),
      .rsp_dest_row     (rsp_dest_row),
      .rsp_out_pixel    (rsp_out_pixel),
      .rsp_region_last  (rsp_region_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Effective size: clamp to MAX_DIM, and for region sizes treat zero as one.
   function automatic int dim_clamp(input logic [ckb_pkg::CFG_DIM_W-1:0] size,
                                    input bit zero_as_one);
      if (size == 0) return zero_as_one ? 1 : 0;
      return (size > MAX_DIM) ? MAX_DIM : int'(size);
   endfunction

   // Work out the write decision for one accepted pixel and advance the
   // raster position, exactly as one transfer moves the blitter.
   function automatic blit_write_type blit_predict(input logic [ckb_pkg::PIXEL_W-1:0] pixel);
      int rw, rh, tw, th, dc, dr;
      bit on_target, keyed, row_end;
      blit_write_type w;
      rw = dim_clamp(region_w, 1'b1);
      rh = dim_clamp(region_h, 1'b1);
      tw = dim_clamp(target_w, 1'b0);
      th = dim_clamp(target_h, 1'b0);
      dc = int'(place_col) + col_pos;
      dr = int'(place_row) + row_pos;
      on_target = (dc >= 0) && (dc < tw) && (dr >= 0) && (dr < th);
      keyed = key_on && (pixel == key_value);
      w.spot.strobe = on_target && !keyed;
      w.spot.col = w.spot.strobe ? dc[ckb_pkg::DEST_W-1:0] : '0;
      w.spot.row = w.spot.strobe ? dr[ckb_pkg::DEST_W-1:0] : '0;
      w.pixel = pixel;
      // A position at or past the last column or row counts as on it, which
      // covers a region shrunk while the position sits deep inside it.
      row_end = col_pos >= rw - 1;
      w.last = row_end && (row_pos >= rh - 1);
      if (w.last) begin
         col_pos = 0;
         row_pos = 0;
      end else if (row_end) begin
         col_pos = 0;
         row_pos = row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
      return w;
   endfunction

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endfunction

   // Write one register and mirror it. Enable stays high for back-to-back writes.
   task automatic write_csr(input ckb_pkg::csr_index_type idx,
                            input logic [ckb_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= value;
      case (idx)
         ckb_pkg::REG_PLACE_X:       place_col = value[ckb_pkg::PLACE_W-1:0];
         ckb_pkg::REG_PLACE_Y:       place_row = value[ckb_pkg::PLACE_W-1:0];
         ckb_pkg::REG_REGION_WIDTH:  region_w  = value[ckb_pkg::CFG_DIM_W-1:0];
         ckb_pkg::REG_REGION_HEIGHT: region_h  = value[ckb_pkg::CFG_DIM_W-1:0];
         ckb_pkg::REG_TARGET_WIDTH:  target_w  = value[ckb_pkg::CFG_DIM_W-1:0];
         ckb_pkg::REG_TARGET_HEIGHT: target_h  = value[ckb_pkg::CFG_DIM_W-1:0];
         ckb_pkg::REG_KEY_COLOR:     key_value = value;
         ckb_pkg::REG_KEY_ENABLE:    key_on    = value[0];
         default: ;
      endcase
   endtask

   // Write all eight registers. Bits above each register's width carry random
   // junk, so the block must ignore them.
   task automatic write_settings(input int px, py, rw, rh, tw, th,
                                 input logic [ckb_pkg::PIXEL_W-1:0] kc, input bit ke);
      logic [ckb_pkg::CSR_DATA_W-1:0] word;
      word = $urandom(); word[ckb_pkg::PLACE_W-1:0] = px[ckb_pkg::PLACE_W-1:0];
      write_csr(ckb_pkg::REG_PLACE_X, word);
      word = $urandom(); word[ckb_pkg::PLACE_W-1:0] = py[ckb_pkg::PLACE_W-1:0];
      write_csr(ckb_pkg::REG_PLACE_Y, word);
      word = $urandom(); word[ckb_pkg::CFG_DIM_W-1:0] = rw[ckb_pkg::CFG_DIM_W-1:0];
      write_csr(ckb_pkg::REG_REGION_WIDTH, word);
      word = $urandom(); word[ckb_pkg::CFG_DIM_W-1:0] = rh[ckb_pkg::CFG_DIM_W-1:0];
      write_csr(ckb_pkg::REG_REGION_HEIGHT, word);
      word = $urandom(); word[ckb_pkg::CFG_DIM_W-1:0] = tw[ckb_pkg::CFG_DIM_W-1:0];
      write_csr(ckb_pkg::REG_TARGET_WIDTH, word);
      word = $urandom(); word[ckb_pkg::CFG_DIM_W-1:0] = th[ckb_pkg::CFG_DIM_W-1:0];
      write_csr(ckb_pkg::REG_TARGET_HEIGHT, word);
      write_csr(ckb_pkg::REG_KEY_COLOR, kc);
      word = $urandom(); word[0] = ke;
      write_csr(ckb_pkg::REG_KEY_ENABLE, word);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Block until no pixel waits, none is in flight and every result is back,
   // then let the two pipeline stages go quiet before any csr write.
   task automatic settle();
      @(negedge clock);
      while (pixel_backlog.size() != 0 || req_valid || pending_writes.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One random phase: fresh settings, then mostly whole regions, sometimes a
   // cut-off region that the next phase's settings then resize under.
   task automatic random_phase(inout int sent);
      int rw, rh, tw, th, px, py, n, full;
      logic [ckb_pkg::PIXEL_W-1:0] kc;
      bit ke;
      int pick;

      pick = $urandom_range(0, 9);
      rw = (pick == 0) ? 0 : (pick == 9) ? $urandom_range(13, 32) : $urandom_range(1, 12);
      pick = $urandom_range(0, 9);
      rh = (pick == 0) ? 0 : $urandom_range(1, 8);

      pick = $urandom_range(0, 9);
      tw = (pick < 6) ? $urandom_range(1, 64) : (pick == 6) ? 0 :
           (pick == 7) ? $urandom_range(4096, 8191) : (pick == 8) ? 4096 : $urandom_range(0, 8191);
      pick = $urandom_range(0, 9);
      th = (pick < 6) ? $urandom_range(1, 64) : (pick == 6) ? 0 :
           (pick == 7) ? $urandom_range(4096, 8191) : (pick == 8) ? 4096 : $urandom_range(0, 8191);

      pick = $urandom_range(0, 9);
      px = (pick < 6) ? $urandom_range(0, 90) - 20 : (pick == 6) ? -4096 :
           (pick == 7) ? 4095 : $urandom_range(0, 8191);
      pick = $urandom_range(0, 9);
      py = (pick < 6) ? $urandom_range(0, 90) - 20 : (pick == 6) ? -4096 :
           (pick == 7) ? 4095 : $urandom_range(0, 8191);

      kc = $urandom();
      ke = ($urandom_range(0, 1) != 0);
      write_settings(px, py, rw, rh, tw, th, kc, ke);

      full = dim_clamp(rw[ckb_pkg::CFG_DIM_W-1:0], 1'b1) *
             dim_clamp(rh[ckb_pkg::CFG_DIM_W-1:0], 1'b1);
      if ($urandom_range(0, 9) < 7) n = full * $urandom_range(1, 2);
      else n = $urandom_range(1, full + 3);

      idle_on = ($urandom_range(0, 3) != 0);
      // Hit the key value often, whether keying is on or not.
      repeat (n) pixel_backlog.push_back(($urandom_range(0, 3) == 0) ? kc : $urandom());
      sent += n;
      settle();
   endtask

   // Driver: offer the next pixel when the channel is free, with random gaps.
   // On each transfer, log the write that pixel should cause.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         if (req_valid && req_ready) pending_writes.push_back(blit_predict(req_src_pixel));
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pixel_backlog.size() != 0) begin
               req_valid     <= 1'b1;
               req_src_pixel <= pixel_backlog.pop_front();
               gap_left      <= idle_on ? pick_gap() : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stall the result side at random, check each transfer against
   // the oldest expected write, and count cycles where pending work stands still.
   always @(posedge clock) begin
      blit_write_type want;
      if (reset) begin
         rsp_ready    <= 1'b0;
         stall_left   <= 0;
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_writes.size() == 0) begin
               $display("%0t: result with nothing expected, expected none, actual pixel %h",
                        $time, rsp_out_pixel);
               error_count++;
            end else begin
               want = pending_writes.pop_front();
               check_field("write_strobe", 32'(want.spot.strobe), 32'(rsp_write_strobe));
               check_field("dest_col", 32'(want.spot.col), 32'(rsp_dest_col));
               check_field("dest_row", 32'(want.spot.row), 32'(rsp_dest_row));
               check_field("out_pixel", want.pixel, rsp_out_pixel);
               check_field("region_last", 32'(want.last), 32'(rsp_region_last));
            end
         end

         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
         end

         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (pixel_backlog.size() == 0 && !req_valid && pending_writes.size() == 0))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Watchdog: give up once pending work has made no transfer for too long.
   initial begin
      do @(posedge clock); while (quiet_cycles < STALL_LIMIT);
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int random_sent;
      random_sent = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      settle();

      // Reset settings: a 1x1 region at the origin, so every pixel is last.
      pixel_backlog.push_back(32'h0000_0000);
      pixel_backlog.push_back(32'hFFFF_FFFF);
      settle();

      // Region straddles the left edge and the bottom two rows; the target
      // width is oversized and acts as MAX_DIM; one on-target pixel is keyed.
      write_settings(-2, 4094, 3, 2, 5000, 4096, 32'hA5A5_A5A5, 1'b1);
      pixel_backlog.push_back(32'hFFFF_0000);
      pixel_backlog.push_back(32'h1234_5678);
      pixel_backlog.push_back(32'hA5A5_A5A5);
      pixel_backlog.push_back(32'h5A5A_5A5A);
      pixel_backlog.push_back(32'h0000_FFFF);
      pixel_backlog.push_back(32'h8000_0001);
      settle();

      // Zero region size acts as one; zero target width clips everything.
      write_settings(4095, -4096, 0, 0, 0, 4096, 32'h0000_0000, 1'b1);
      pixel_backlog.push_back(32'h0000_0000);
      pixel_backlog.push_back(32'h7FFF_FFFF);
      settle();

      // Stop partway into a 4x3 region near the right edge, with keying off
      // and a pixel equal to the key value.
      write_settings(4094, 0, 4, 3, 4096, 2, 32'h0F0F_0F0F, 1'b0);
      pixel_backlog.push_back(32'h0F0F_0F0F);
      pixel_backlog.push_back(32'h0000_0001);
      pixel_backlog.push_back(32'h0000_0002);
      pixel_backlog.push_back(32'h0000_0003);
      pixel_backlog.push_back(32'h0000_0004);
      settle();

      // Shrink the region to 1x1 under the live position: the next pixel
      // closes the region and the one after starts fresh at the top-left.
      write_settings(4094, 0, 1, 1, 4096, 2, 32'h0F0F_0F0F, 1'b0);
      pixel_backlog.push_back(32'hC0DE_0001);
      pixel_backlog.push_back(32'hC0DE_0002);
      settle();

      while (random_sent < RANDOM_ITEMS) begin
         random_phase(random_sent);
         // At most once, run part of a row whose oversized width acts as MAX_DIM, so
         // no row ends inside it; the next phase then resizes under it.
         if (random_sent >= RANDOM_ITEMS / 2 && random_sent < RANDOM_ITEMS / 2 + 40) begin
            write_settings(-10, 0, $urandom_range(4097, 8191), 1, 4096, 1, $urandom(), 1'b0);
            idle_on = 1'b0;
            repeat (40) pixel_backlog.push_back($urandom());
            settle();
            random_sent += 40;
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== color_key_sprite_blitter_unit.f =====
+incdir+src
src/ckb_pkg.sv
src/ckb_locate.sv
src/color_key_sprite_blitter_unit.sv
test/tb_color_key_sprite_blitter_unit.sv
